>>> hw/rtl/pool_draw_without_replacement_macros.svh
// ----------------------------------------------------------------------------
// pool draw assertion macros
// shared property wrappers, clocked on i_clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef POOL_DRAW_WITHOUT_REPLACEMENT_MACROS_SVH
`define POOL_DRAW_WITHOUT_REPLACEMENT_MACROS_SVH

// same-cycle implication
`define PDWR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PDWR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pdwr_pkg.sv
// ----------------------------------------------------------------------------
// pdwr_pkg
// shared widths, reset sizes, sequencer states and divider bundles
// ----------------------------------------------------------------------------
`default_nettype none

package pdwr_pkg;

    localparam int ENTRY_W     = 7;
    localparam int SIZE_W      = 8;
    localparam int RND_W       = 16;
    localparam int POOL_FLD_W  = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_SIZE_REGS = 7;
    localparam int RESET_SLOTS = 8;
    localparam int STEP_W      = $clog2(RND_W);

    // pool size after reset, last slot covers an eighth pool
    localparam logic [SIZE_W-1:0] SIZE_RESET [RESET_SLOTS] = '{
        8'd119, 8'd78, 8'd98, 8'd5, 8'd15, 8'd6, 8'd3, 8'd128
    };

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_RD_R,
        ST_RD_L,
        ST_WR_R,
        ST_WR_L
    } t_state;

    typedef struct packed {
        logic              start;
        logic [RND_W-1:0]  dividend;
        logic [SIZE_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] rem;
    } t_mod_rsp;

endpackage

`default_nettype wire

>>> hw/rtl/pdwr_ram.sv
// ----------------------------------------------------------------------------
// pdwr_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pdwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/pdwr_mod.sv
// ----------------------------------------------------------------------------
// pdwr_mod
// bit-serial restoring modulo, one dividend bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pdwr_mod (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pdwr_pkg::t_mod_req i_req,
    output pdwr_pkg::t_mod_rsp      o_rsp
);

    import pdwr_pkg::*;

    logic              r_run;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [RND_W-1:0]  r_dvd;
    logic [SIZE_W-1:0] r_div;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] n_rem;
    logic [SIZE_W:0]   w_trial;

    // shift in next dividend bit, subtract when it fits
    always_comb begin
        w_trial = {r_rem, r_dvd[RND_W-1]};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = SIZE_W'(w_trial - {1'b0, r_div});
        end else begin
            n_rem = SIZE_W'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(RND_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= {r_dvd[RND_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

>>> hw/rtl/pool_draw_without_replacement.sv
// ----------------------------------------------------------------------------
// pool_draw_without_replacement
// incremental fisher-yates draw from up to eight pools of shuffled entries
// ----------------------------------------------------------------------------
//
//   channel   | handshake                    | beat contents
//   ----------+------------------------------+----------------------------
//   draw in   | i_start, o_busy              | i_pool, i_random_value
//   result    | o_valid (one-cycle strobe)   | o_entry, o_error
//   config    | i_cfg_valid, o_cfg_ready     | i_cfg_index, i_cfg_data
//
// a draw runs from its accept edge through the modulo state (one shift step per dividend
// bit, then the registered done), two reads and two writes on the pool memory, then the
// result register. the next draw is taken once busy drops, while the result is shown; an invalid
// pool gives its error beat on the next cycle with busy low. after a synchronous
// active-low reset a clearing pass over all NUM_POOLS * 2**clog2(MAX_ENTRIES) table
// slots (896 at the defaults) holds busy high.
// ----------------------------------------------------------------------------
`default_nettype none

module pool_draw_without_replacement #(
    parameter int NUM_POOLS   = 7,
    parameter int MAX_ENTRIES = 128
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // draw command
    input  wire logic                             i_start,
    output logic                                  o_busy,
    input  wire logic [pdwr_pkg::POOL_FLD_W-1:0]  i_pool,
    input  wire logic [pdwr_pkg::RND_W-1:0]       i_random_value,
    // result strobe
    output logic                                  o_valid,
    output logic      [pdwr_pkg::ENTRY_W-1:0]     o_entry,
    output logic                                  o_error,
    // config write
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [pdwr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pdwr_pkg::SIZE_W-1:0]      i_cfg_data
);

    import pdwr_pkg::*;

    `include "pool_draw_without_replacement_macros.svh"

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int POOL_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int DEPTH  = NUM_POOLS << IDX_W;
    localparam int ADDR_W = $clog2(DEPTH);
    // largest usable size: the largest register value or the row length
    localparam logic [SIZE_W-1:0] SIZE_CAP =
        (MAX_ENTRIES > (2**SIZE_W - 1)) ? SIZE_W'(2**SIZE_W - 1) : SIZE_W'(MAX_ENTRIES);

    // sequencer
    t_state r_state;
    t_state n_state;

    // per-pool config and draw counts
    logic [SIZE_W-1:0] r_pool_size [NUM_POOLS];
    logic [SIZE_W-1:0] r_drawn     [NUM_POOLS];

    // draw in flight
    logic [POOL_W-1:0]  r_pool_idx;
    logic [SIZE_W-1:0]  r_last;
    logic [SIZE_W-1:0]  r_cnt_next;
    logic [ENTRY_W-1:0] r_picked;
    logic [ADDR_W-1:0]  r_clr_addr;

    // result register
    logic               r_valid;
    logic               r_error;
    logic [ENTRY_W-1:0] r_entry;
    logic               n_valid;
    logic               n_error;
    logic [ENTRY_W-1:0] n_entry;

    // accept and pool lookup
    logic              w_accept;
    logic              w_pool_ok;
    logic [POOL_W-1:0] w_pool_idx;
    logic [SIZE_W-1:0] w_size_raw;
    logic [SIZE_W-1:0] w_size;
    logic [SIZE_W-1:0] w_cnt;
    logic [SIZE_W-1:0] w_cnt_use;
    logic [SIZE_W-1:0] w_divisor;
    logic              w_cfg_we;
    logic              w_clr_last;

    // memory port
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic [ADDR_W-1:0]  w_raddr;
    logic [ENTRY_W-1:0] w_rdata;
    logic [ADDR_W-1:0]  w_addr_r;
    logic [ADDR_W-1:0]  w_addr_l;

    t_mod_req w_mod_req;
    t_mod_rsp w_mod_rsp;

    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_start && !o_busy;
    assign w_pool_ok   = (32'(i_pool) < NUM_POOLS);
    assign w_pool_idx  = POOL_W'(i_pool);
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_clr_last  = (r_clr_addr == ADDR_W'(DEPTH - 1));

    // effective size: zero reads as one, large values clip to the row
    assign w_size_raw = r_pool_size[w_pool_idx];
    always_comb begin
        if (w_size_raw == '0) begin
            w_size = SIZE_W'(1);
        end else if (w_size_raw > SIZE_CAP) begin
            w_size = SIZE_CAP;
        end else begin
            w_size = w_size_raw;
        end
    end

    // full pool (or one shrunk under its count) starts over
    assign w_cnt     = r_drawn[w_pool_idx];
    assign w_cnt_use = (w_cnt >= w_size) ? '0 : w_cnt;
    assign w_divisor = w_size - w_cnt_use;

    // modulo unit starts at the accept edge of a draw on a valid pool
    assign w_mod_req.start    = w_accept && w_pool_ok;
    assign w_mod_req.dividend = i_random_value;
    assign w_mod_req.divisor  = w_divisor;

    pdwr_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mod_req),
        .o_rsp   (w_mod_rsp)
    );

    // slot addresses: pool in the upper bits, slot in the lower
    assign w_addr_r = ADDR_W'({r_pool_idx, IDX_W'(w_mod_rsp.rem)});
    assign w_addr_l = ADDR_W'({r_pool_idx, IDX_W'(r_last)});

    pdwr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (w_clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept && w_pool_ok) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_mod_rsp.done) begin
                    n_state = ST_RD_R;
                end
            end
            ST_RD_R: n_state = ST_RD_L;
            ST_RD_L: n_state = ST_WR_R;
            ST_WR_R: n_state = ST_WR_L;
            ST_WR_L: n_state = ST_IDLE;
            default: n_state = ST_CLEAR;
        endcase
    end

    // memory control and result
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_addr_r;
        w_wdata = w_rdata;
        w_raddr = w_addr_r;
        n_valid = 1'b0;
        n_error = 1'b0;
        n_entry = r_picked;
        unique case (r_state)
            ST_CLEAR: begin
                // identity load, slot index masked to the entry width
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = ENTRY_W'(r_clr_addr[IDX_W-1:0]);
            end
            ST_IDLE: begin
                if (w_accept && !w_pool_ok) begin
                    n_valid = 1'b1;
                    n_error = 1'b1;
                    n_entry = '0;
                end
            end
            ST_DIV: begin
            end
            ST_RD_R: begin
                w_raddr = w_addr_r;
            end
            ST_RD_L: begin
                // picked slot data lands this cycle
                w_raddr = w_addr_l;
            end
            ST_WR_R: begin
                // last slot data moves into the picked slot
                w_we    = 1'b1;
                w_waddr = w_addr_r;
                w_wdata = w_rdata;
            end
            ST_WR_L: begin
                w_we    = 1'b1;
                w_waddr = w_addr_l;
                w_wdata = r_picked;
                n_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // payload of the draw in flight
    always_ff @(posedge i_clk) begin
        r_error <= n_error;
        r_entry <= n_entry;
        if (w_mod_req.start) begin
            r_pool_idx <= w_pool_idx;
            r_last     <= w_divisor - 1'b1;
            r_cnt_next <= w_cnt_use + 1'b1;
        end
        if (r_state == ST_RD_L) begin
            r_picked <= w_rdata;
        end
    end

    // size registers and draw counts, one per pool
    for (genvar p = 0; p < NUM_POOLS; p++) begin : g_pool
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pool_size[p] <= SIZE_RESET[p];
                r_drawn[p]     <= '0;
            end else begin
                if (w_cfg_we && (i_cfg_index == CFG_IDX_W'(p)) && (p < NUM_SIZE_REGS)) begin
                    r_pool_size[p] <= i_cfg_data;
                end
                if ((r_state == ST_WR_L) && (r_pool_idx == POOL_W'(p))) begin
                    r_drawn[p] <= r_cnt_next;
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_error = r_error;
    assign o_entry = r_entry;

    // checks
    `PDWR_ASSERT_IMPLY(a_clear_quiet, r_state == ST_CLEAR, !o_valid, "result beat during clear")
    `PDWR_ASSERT_NEXT(a_bad_pool, w_accept && !w_pool_ok, o_valid && o_error && (o_entry == '0), "bad pool gave no error beat")
    `PDWR_ASSERT_NEXT(a_draw_start, w_accept && w_pool_ok, !o_valid && (r_state == ST_DIV), "draw did not enter modulo")
    `PDWR_ASSERT_IMPLY(a_mod_done, w_mod_rsp.done, r_state == ST_DIV, "modulo done outside divide")

endmodule

`default_nettype wire

>>> dv/pool_draw_without_replacement_checker.sv
// ----------------------------------------------------------------------------
// pool_draw_without_replacement_checker
// watches the draw, result and config channels, keeps its own copy of the
// shuffled pools and compares every result beat against the predicted draw
// ----------------------------------------------------------------------------
module pool_draw_without_replacement_checker #(
    parameter int NUM_POOLS   = 7,
    parameter int MAX_ENTRIES = 128
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  logic [pdwr_pkg::POOL_FLD_W-1:0]  i_pool,
    input  logic [pdwr_pkg::RND_W-1:0]       i_random_value,
    input  logic                             i_valid,
    input  logic [pdwr_pkg::ENTRY_W-1:0]     i_entry,
    input  logic                             i_error,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [pdwr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pdwr_pkg::SIZE_W-1:0]      i_cfg_data,
    output int                               o_mismatches,
    output int                               o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import pdwr_pkg::*;

    typedef struct packed {
        logic [ENTRY_W-1:0] entry;
        logic               error;
    } t_draw_beat;

    logic [ENTRY_W-1:0] shuffled [NUM_POOLS][MAX_ENTRIES];
    logic [SIZE_W-1:0]  drawn    [NUM_POOLS];
    logic [SIZE_W-1:0]  pool_size[NUM_POOLS];
    t_draw_beat         pending_draws[$];
    int                 mismatches = 0;
    t_draw_beat         predicted;
    t_draw_beat         oldest;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    // one incremental fisher-yates step on the local pool copy
    task automatic draw_from_pool(input logic [POOL_FLD_W-1:0] pool,
                                  input logic [RND_W-1:0] rnd,
                                  output t_draw_beat beat);
        int unsigned span;
        int unsigned cnt;
        int unsigned slot;
        int unsigned last_slot;
        logic [ENTRY_W-1:0] picked;
        beat = '0;
        if (int'(pool) >= NUM_POOLS) begin
            beat.error = 1'b1;
            return;
        end
        span = pool_size[pool];
        // zero counts as one, oversize saturates to the table depth
        if (span == 0) span = 1;
        if (span > MAX_ENTRIES) span = MAX_ENTRIES;
        cnt = drawn[pool];
        // full pool, or size lowered under the count: start a new round
        if (cnt >= span) cnt = 0;
        slot      = int'(rnd) % (span - cnt);
        last_slot = span - 1 - cnt;
        picked                      = shuffled[pool][slot];
        shuffled[pool][slot]        = shuffled[pool][last_slot];
        shuffled[pool][last_slot]   = picked;
        drawn[pool]                 = SIZE_W'(cnt + 1);
        beat.entry                  = picked;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_POOLS; p++) begin
                for (int e = 0; e < MAX_ENTRIES; e++)
                    shuffled[p][e] = ENTRY_W'(e);
                drawn[p]     = '0;
                pool_size[p] = SIZE_RESET[p % RESET_SLOTS];
            end
            pending_draws.delete();
        end else begin
            if (i_valid) begin
                if (pending_draws.size() == 0) begin
                    $error("result beat with no draw outstanding: entry %0d error %0d",
                           i_entry, i_error);
                    mismatches++;
                end else begin
                    oldest = pending_draws.pop_front();
                    if (i_entry !== oldest.entry) begin
                        $error("entry mismatch: expected %0d, got %0d", oldest.entry, i_entry);
                        mismatches++;
                    end
                    if (i_error !== oldest.error) begin
                        $error("error mismatch: expected %0d, got %0d", oldest.error, i_error);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (int'(i_cfg_index) < NUM_SIZE_REGS && int'(i_cfg_index) < NUM_POOLS)
                    pool_size[i_cfg_index] = i_cfg_data;
            end
            if (i_start && !i_busy) begin
                draw_from_pool(i_pool, i_random_value, predicted);
                pending_draws.push_back(predicted);
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= pending_draws.size();
    end

endmodule

>>> dv/pool_draw_without_replacement_test.sv
// ----------------------------------------------------------------------------
// pool_draw_without_replacement_test
// drives directed and random draws and pool size writes into the block, with
// a side checker predicting every result beat; passes on zero mismatches
// ----------------------------------------------------------------------------
module pool_draw_without_replacement_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pdwr_pkg::*;

    localparam int NUM_POOLS      = 7;
    localparam int MAX_ENTRIES    = 128;
    localparam int INVALID_POOL   = 7;
    localparam int SETTLE_CYCLES  = 30;
    localparam int WATCHDOG_LIMIT = 5000;   // covers the clearing pass
    localparam int NUM_PHASES     = 9;
    localparam int PHASE_DRAWS    = 190;

    // sender idle percentages per phase: none, heavy, light
    localparam int IDLE_PCT [3] = '{0, 77, 19};

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_start        = 1'b0;
    logic [POOL_FLD_W-1:0]  i_pool         = '0;
    logic [RND_W-1:0]       i_random_value = '0;
    logic                   i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index    = '0;
    logic [SIZE_W-1:0]      i_cfg_data     = '0;
    logic                   o_busy;
    logic                   o_valid;
    logic [ENTRY_W-1:0]     o_entry;
    logic                   o_error;
    logic                   o_cfg_ready;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;

    always #6ns i_clk = ~i_clk;

    pool_draw_without_replacement #(
        .NUM_POOLS   (NUM_POOLS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_pool         (i_pool),
        .i_random_value (i_random_value),
        .o_valid        (o_valid),
        .o_entry        (o_entry),
        .o_error        (o_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    pool_draw_without_replacement_checker #(
        .NUM_POOLS   (NUM_POOLS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_pool         (i_pool),
        .i_random_value (i_random_value),
        .i_valid        (o_valid),
        .i_entry        (o_entry),
        .i_error        (o_error),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    // watchdog: any accepted beat on any channel resets the quiet count
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("pool_draw_without_replacement_test: FAIL");
            $finish;
        end
    end

    // present one draw beat and hold it until the block takes it;
    // start is left high so a following beat can go back to back
    task automatic send_draw(input logic [POOL_FLD_W-1:0] pool,
                             input logic [RND_W-1:0] rnd);
        i_start        <= 1'b1;
        i_pool         <= pool;
        i_random_value <= rnd;
        do @(posedge i_clk); while (o_busy);
    endtask

    // one size register write, valid left high for the next beat
    task automatic write_size(input logic [CFG_IDX_W-1:0] idx,
                              input logic [SIZE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // sender pause until every predicted result has come back
    task automatic wait_drain();
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // bring the block to idle before touching the size registers
    task automatic settle();
        i_start <= 1'b0;
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // random size for one register, leaning on extremes and small pools
    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(9))
            0: return '0;
            1: return SIZE_W'($urandom_range(129, 255));
            2: return SIZE_W'(MAX_ENTRIES);
            3: return SIZE_W'(1);
            4, 5, 6: return SIZE_W'($urandom_range(1, 8));
            default: return SIZE_W'($urandom_range(1, MAX_ENTRIES));
        endcase
    endfunction

    initial begin
        int idle_pct;
        int favorite;
        int pick;
        logic [POOL_FLD_W-1:0] pool;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // clearing pass keeps busy high
        do @(posedge i_clk); while (o_busy);

        // ---- directed: reset sizes ----
        // pool six holds three entries, the fourth draw starts a new round
        send_draw(3'd6, 16'h0000);
        send_draw(3'd6, 16'hFFFF);
        send_draw(3'd6, 16'hAAAA);
        send_draw(3'd6, 16'h5555);
        // no pool behind this number
        send_draw(POOL_FLD_W'(INVALID_POOL), 16'hFFFF);
        send_draw(POOL_FLD_W'(INVALID_POOL), 16'h0000);
        send_draw(3'd0, 16'hFFFF);
        // three draws on pool one, then its size drops under the count
        send_draw(3'd1, 16'h0000);
        send_draw(3'd1, 16'h0000);
        send_draw(3'd1, 16'h0000);
        settle();

        // ---- directed: size extremes ----
        write_size(3'd1, 8'd2);
        write_size(3'd3, 8'd0);           // zero acts as one
        write_size(3'd4, 8'd255);         // saturates to the table depth
        write_size(3'd5, 8'd128);
        write_size(3'd2, 8'd1);
        write_size(3'd7, 8'd9);           // no register here, write dropped
        write_size(3'd0, 8'd129);
        write_size(3'd6, 8'd128);
        i_cfg_valid <= 1'b0;
        send_draw(3'd1, 16'h0005);
        send_draw(3'd1, 16'h0001);
        send_draw(3'd3, 16'hFFFF);
        send_draw(3'd3, 16'hFFFF);
        send_draw(3'd4, 16'hFFFF);        // top entry of an untouched full pool
        send_draw(3'd5, 16'h007F);
        send_draw(3'd2, 16'h0003);
        send_draw(3'd0, 16'hFFFF);
        send_draw(3'd6, 16'h8000);
        settle();

        // ---- random phases ----
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            for (int r = 0; r < 8; r++)
                write_size(CFG_IDX_W'(r), pick_size());
            i_cfg_valid <= 1'b0;
            idle_pct = IDLE_PCT[ph % 3];
            // most beats hit one pool so its rounds wrap several times
            favorite = $urandom_range(0, NUM_POOLS - 1);
            for (int n = 0; n < PHASE_DRAWS; n++) begin
                pick = $urandom_range(99);
                if (pick < 80)
                    pool = POOL_FLD_W'(favorite);
                else if (pick < 94)
                    pool = POOL_FLD_W'($urandom_range(0, NUM_POOLS - 1));
                else
                    pool = POOL_FLD_W'(INVALID_POOL);
                if ($urandom_range(99) < 2) begin
                    i_start <= 1'b0;
                    wait_drain();
                end else if ($urandom_range(99) < idle_pct) begin
                    // gap length spread over the whole draw time
                    i_start <= 1'b0;
                    repeat ($urandom_range(1, 28)) @(posedge i_clk);
                end
                send_draw(pool, RND_W'($urandom_range(0, 65535)));
            end
            settle();
        end

        // settle() already drained and waited out the draw latency
        if (mismatches == 0 && outstanding == 0)
            $display("pool_draw_without_replacement_test: PASS");
        else
            $display("pool_draw_without_replacement_test: FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/pdwr_pkg.sv
hw/rtl/pdwr_ram.sv
hw/rtl/pdwr_mod.sv
hw/rtl/pool_draw_without_replacement.sv
dv/pool_draw_without_replacement_checker.sv
dv/pool_draw_without_replacement_test.sv
